// ===== rtl/multilevel_feedback_thread_scheduler_top_defines.svh =====
// assertion macros for the thread scheduler checker
`ifndef MULTILEVEL_FEEDBACK_THREAD_SCHEDULER_TOP_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_THREAD_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MFTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler port check failed");

// next-cycle implication, disabled in reset
`define MFTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler port check failed");

`endif

// ===== rtl/mfts_pkg.sv =====
// shared constants, codes and controller/datapath interface types
package mfts_pkg;

    localparam int THREADS = 16;
    localparam int LEVELS  = 4;
    localparam int MUTEXES = 4;
    localparam int TICK_W  = 32;

    localparam int SLOT_W  = $clog2(THREADS);
    localparam int PTR_W   = SLOT_W + 1;
    localparam int LVL_W   = $clog2(LEVELS);
    localparam int MI_W    = 2;
    localparam int PRIO_W  = 3;
    localparam int ACT_W   = 4;
    localparam int STAT_W  = 2;
    localparam int BQ_W    = 8;
    localparam int LIM_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 16;
    localparam int SLICE_W = BQ_W + LEVELS - 1;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(THREADS);

    // thread states
    localparam logic [2:0] TS_UNUSED   = 3'd0;
    localparam logic [2:0] TS_READY    = 3'd1;
    localparam logic [2:0] TS_RUNNING  = 3'd2;
    localparam logic [2:0] TS_SLEEPING = 3'd3;
    localparam logic [2:0] TS_BLOCKED  = 3'd4;
    localparam logic [2:0] TS_ZOMBIE   = 3'd5;

    // commands
    localparam logic [ACT_W-1:0] ACT_TICK    = 4'd0;
    localparam logic [ACT_W-1:0] ACT_CREATE  = 4'd1;
    localparam logic [ACT_W-1:0] ACT_YIELD   = 4'd2;
    localparam logic [ACT_W-1:0] ACT_SLEEP   = 4'd3;
    localparam logic [ACT_W-1:0] ACT_BLOCK   = 4'd4;
    localparam logic [ACT_W-1:0] ACT_WAKE    = 4'd5;
    localparam logic [ACT_W-1:0] ACT_EXIT    = 4'd6;
    localparam logic [ACT_W-1:0] ACT_PREEMPT = 4'd7;
    localparam logic [ACT_W-1:0] ACT_IDLE    = 4'd8;
    localparam logic [ACT_W-1:0] ACT_LOCK    = 4'd9;
    localparam logic [ACT_W-1:0] ACT_UNLOCK  = 4'd10;

    // result status
    localparam logic [STAT_W-1:0] RS_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] RS_NOSLOT  = 2'd1;
    localparam logic [STAT_W-1:0] RS_IGNORED = 2'd2;
    localparam logic [STAT_W-1:0] RS_WAITING = 2'd3;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_QUANTUM = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_STARVE  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BOOST   = 2'd2;

    typedef enum logic [3:0] {
        OP_NOP, OP_LATCH, OP_EXEC, OP_DENQ, OP_DDEQ, OP_TINC, OP_WAKE,
        OP_PCHK, OP_WALK, OP_UNLK, OP_PENQ, OP_SLICE, OP_BEST, OP_BOOST, OP_BFIX
    } t_dp_op;

    typedef struct packed {
        logic is_tick;
        logic disp;
        logic i_last;
        logic promo;
        logic walk_done;
        logic boost_due;
        logic boost_end;
    } t_dp_stat;

endpackage

// ===== rtl/mfts_dp.sv =====
// scheduler datapath: thread tables, run queues, mutexes, config registers
module mfts_dp import mfts_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_op              i_op,
    output t_dp_stat            o_stat,
    input  logic [ACT_W-1:0]    i_action,
    input  logic [SLOT_W-1:0]   i_thread_slot,
    input  logic [PRIO_W-1:0]   i_priority_req,
    input  logic [TICK_W-1:0]   i_sleep_ticks,
    input  logic [MI_W-1:0]     i_mutex_index,
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CDAT_W-1:0]   i_cfg_data,
    output logic [SLOT_W-1:0]   o_running_slot,
    output logic                o_switched,
    output logic                o_resched_pending,
    output logic [SLOT_W-1:0]   o_new_slot,
    output logic [STAT_W-1:0]   o_status
);

    logic [BQ_W-1:0]    r_bq;
    logic [LIM_W-1:0]   r_sl;
    logic [LIM_W-1:0]   r_bp;

    logic [ACT_W-1:0]   r_act;
    logic [SLOT_W-1:0]  r_slot;
    logic [PRIO_W-1:0]  r_prio;
    logic [TICK_W-1:0]  r_ticks;
    logic [MI_W-1:0]    r_mi;

    logic [2:0]         r_state [THREADS];
    logic [LVL_W-1:0]   r_lvl   [THREADS];
    logic [LVL_W-1:0]   r_base  [THREADS];
    logic [SLICE_W-1:0] r_slice [THREADS];
    logic [TICK_W-1:0]  r_wake  [THREADS];
    logic [TICK_W-1:0]  r_age   [THREADS];
    logic [PTR_W-1:0]   r_link  [THREADS];
    logic [PTR_W-1:0]   r_wlink [THREADS];
    logic [PTR_W-1:0]   r_qh    [LEVELS];
    logic [PTR_W-1:0]   r_qt    [LEVELS];
    logic [PTR_W-1:0]   r_oh    [LEVELS];
    logic               r_mlock [MUTEXES];
    logic [SLOT_W-1:0]  r_mown  [MUTEXES];
    logic [PTR_W-1:0]   r_wh    [MUTEXES];
    logic [PTR_W-1:0]   r_wt    [MUTEXES];

    logic [SLOT_W-1:0]  r_cur;
    logic [SLOT_W-1:0]  r_before;
    logic [TICK_W-1:0]  r_tick;
    logic [TICK_W-1:0]  r_lboost;
    logic               r_resched;
    logic [STAT_W-1:0]  r_status;
    logic [SLOT_W-1:0]  r_created;

    // walk cursors
    logic [SLOT_W-1:0]  r_i;
    logic [PTR_W-1:0]   r_it;
    logic [PTR_W-1:0]   r_prev;
    logic [PTR_W-1:0]   r_steps;
    logic [LVL_W-1:0]   r_bl;

    logic [SLOT_W-1:0]  c;
    logic [LVL_W-1:0]   c_credit;
    logic               best_ok;
    logic [LVL_W-1:0]   best_p;
    logic               free_ok;
    logic [SLOT_W-1:0]  free_t;
    logic [LVL_W-1:0]   prio_c;
    logic               wake_hit;
    logic               promo_hit;
    logic               wk_ok;
    logic               mi_ok;
    logic [PTR_W-1:0]   mw;
    logic [SLOT_W-1:0]  uw;
    logic [PTR_W-1:0]   dq_h;
    logic [SLOT_W-1:0]  nx;
    logic [SLICE_W-1:0] s_dec;
    logic               walk_go;
    logic               enq_en;
    logic [SLOT_W-1:0]  enq_t;
    logic [LVL_W-1:0]   enq_p;

    function automatic logic [SLICE_W-1:0] slice_for(input logic [BQ_W-1:0] bq,
                                                     input logic [LVL_W-1:0] lv);
        slice_for = SLICE_W'(bq) << lv;
    endfunction

    always_comb begin
        c        = r_cur;
        c_credit = (r_lvl[c] > r_base[c]) ? r_lvl[c] - LVL_W'(1) : r_lvl[c];
        best_ok  = 1'b0;
        best_p   = '0;
        for (int p = LEVELS - 1; p >= 0; p--) begin
            if (r_qh[p] != NIL) begin
                best_ok = 1'b1;
                best_p  = LVL_W'(p);
            end
        end
        free_ok = 1'b0;
        free_t  = '0;
        for (int t = THREADS - 1; t >= 0; t--) begin
            if (r_state[t] == TS_UNUSED) begin
                free_ok = 1'b1;
                free_t  = SLOT_W'(t);
            end
        end
        prio_c    = (int'(r_prio) >= LEVELS) ? LVL_W'(LEVELS - 1) : r_prio[LVL_W-1:0];
        wake_hit  = (r_state[r_i] == TS_SLEEPING) && (r_wake[r_i] <= r_tick);
        promo_hit = (r_state[r_i] == TS_READY) && (r_lvl[r_i] != '0) &&
                    ((r_tick - r_age[r_i]) >= TICK_W'(r_sl));
        wk_ok     = (r_state[r_slot] == TS_BLOCKED) || (r_state[r_slot] == TS_SLEEPING);
        mi_ok     = int'(r_mi) < MUTEXES;
        mw        = r_wh[r_mi];
        uw        = mw[SLOT_W-1:0];
        dq_h      = r_qh[best_p];
        nx        = best_ok ? dq_h[SLOT_W-1:0] : '0;
        s_dec     = (r_slice[c] != '0) ? r_slice[c] - SLICE_W'(1) : '0;
        walk_go   = (r_it != NIL) && (r_it != PTR_W'(r_i)) && (int'(r_steps) < THREADS);
    end

    // at most one enqueue per cycle
    always_comb begin
        enq_en = 1'b0;
        enq_t  = '0;
        enq_p  = '0;
        case (i_op)
            OP_EXEC: begin
                case (r_act)
                    ACT_CREATE: begin
                        enq_en = free_ok;
                        enq_t  = free_t;
                        enq_p  = prio_c;
                    end
                    ACT_WAKE: begin
                        enq_en = wk_ok;
                        enq_t  = r_slot;
                        enq_p  = r_lvl[r_slot];
                    end
                    ACT_UNLOCK: begin
                        enq_en = mi_ok && (mw != NIL) && (r_state[uw] == TS_BLOCKED);
                        enq_t  = uw;
                        enq_p  = r_lvl[uw];
                    end
                    default: enq_en = 1'b0;
                endcase
            end
            OP_DENQ: begin
                enq_en = (r_state[c] == TS_READY) && (c != '0);
                enq_t  = c;
                enq_p  = r_lvl[c];
            end
            OP_WAKE: begin
                enq_en = wake_hit;
                enq_t  = r_i;
                enq_p  = r_lvl[r_i];
            end
            OP_PENQ: begin
                enq_en = 1'b1;
                enq_t  = r_i;
                enq_p  = r_lvl[r_i] - LVL_W'(1);
            end
            OP_BOOST: begin
                enq_en = (r_it != NIL);
                enq_t  = r_it[SLOT_W-1:0];
                enq_p  = r_base[r_it[SLOT_W-1:0]];
            end
            default: enq_en = 1'b0;
        endcase
    end

    always_comb begin
        o_stat.is_tick = (r_act == ACT_TICK);
        case (r_act) inside
            ACT_YIELD, ACT_SLEEP, ACT_BLOCK, ACT_EXIT: o_stat.disp = 1'b1;
            ACT_PREEMPT: o_stat.disp = r_resched;
            ACT_IDLE:    o_stat.disp = (c == '0) && best_ok;
            ACT_LOCK:    o_stat.disp = mi_ok && r_mlock[r_mi];
            default:     o_stat.disp = 1'b0;
        endcase
        o_stat.i_last    = (r_i == SLOT_W'(THREADS - 1));
        o_stat.promo     = promo_hit;
        o_stat.walk_done = !walk_go;
        o_stat.boost_due = (r_tick - r_lboost) >= TICK_W'(r_bp);
        o_stat.boost_end = (r_it == NIL) && (r_bl == LVL_W'(LEVELS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bq      <= BQ_W'(4);
            r_sl      <= LIM_W'(100);
            r_bp      <= LIM_W'(1000);
            for (int t = 0; t < THREADS; t++) begin
                r_state[t] <= TS_UNUSED;
                r_lvl[t]   <= '0;
                r_base[t]  <= '0;
                r_slice[t] <= '0;
                r_wake[t]  <= '0;
                r_age[t]   <= '0;
                r_link[t]  <= NIL;
                r_wlink[t] <= NIL;
            end
            r_state[0] <= TS_RUNNING;
            r_lvl[0]   <= LVL_W'(LEVELS - 1);
            r_base[0]  <= LVL_W'(LEVELS - 1);
            for (int p = 0; p < LEVELS; p++) begin
                r_qh[p] <= NIL;
                r_qt[p] <= NIL;
                r_oh[p] <= NIL;
            end
            for (int m = 0; m < MUTEXES; m++) begin
                r_mlock[m] <= 1'b0;
                r_mown[m]  <= '0;
                r_wh[m]    <= NIL;
                r_wt[m]    <= NIL;
            end
            r_cur     <= '0;
            r_before  <= '0;
            r_tick    <= '0;
            r_lboost  <= '0;
            r_resched <= 1'b0;
            r_status  <= RS_DONE;
            r_created <= '0;
            r_i       <= '0;
            r_it      <= NIL;
            r_prev    <= NIL;
            r_steps   <= '0;
            r_bl      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_QUANTUM: r_bq <= i_cfg_data[BQ_W-1:0];
                    CFG_STARVE:  r_sl <= i_cfg_data;
                    CFG_BOOST:   r_bp <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_op)
                OP_LATCH: begin
                    r_act     <= i_action;
                    r_slot    <= i_thread_slot;
                    r_prio    <= i_priority_req;
                    r_ticks   <= i_sleep_ticks;
                    r_mi      <= i_mutex_index;
                    r_before  <= r_cur;
                    r_status  <= RS_DONE;
                    r_created <= '0;
                end
                OP_EXEC: begin
                    case (r_act)
                        ACT_CREATE: begin
                            if (!free_ok) begin
                                r_status <= RS_NOSLOT;
                            end else begin
                                r_base[free_t]  <= prio_c;
                                r_lvl[free_t]   <= prio_c;
                                r_slice[free_t] <= slice_for(r_bq, prio_c);
                                r_wake[free_t]  <= '0;
                                r_wlink[free_t] <= NIL;
                                if (prio_c < r_lvl[c]) r_resched <= 1'b1;
                                r_created <= free_t;
                            end
                        end
                        ACT_YIELD: begin
                            r_lvl[c]   <= c_credit;
                            r_state[c] <= TS_READY;
                        end
                        ACT_SLEEP: begin
                            r_lvl[c] <= c_credit;
                            if (r_ticks == '0) begin
                                r_state[c] <= TS_READY;
                            end else begin
                                r_wake[c]  <= r_tick + r_ticks;
                                r_state[c] <= TS_SLEEPING;
                            end
                        end
                        ACT_BLOCK: begin
                            r_lvl[c]   <= c_credit;
                            r_state[c] <= TS_BLOCKED;
                        end
                        ACT_WAKE: begin
                            if (!wk_ok) r_status <= RS_IGNORED;
                            else if (r_lvl[r_slot] < r_lvl[c]) r_resched <= 1'b1;
                        end
                        ACT_EXIT: r_state[c] <= TS_ZOMBIE;
                        ACT_PREEMPT: begin
                            if (!r_resched) r_status <= RS_IGNORED;
                            else if (r_state[c] == TS_RUNNING) r_state[c] <= TS_READY;
                        end
                        ACT_IDLE: begin
                            if (c != '0 || !best_ok) r_status <= RS_IGNORED;
                            else r_state[0] <= TS_READY;
                        end
                        ACT_LOCK: begin
                            if (!mi_ok) begin
                                r_status <= RS_IGNORED;
                            end else if (!r_mlock[r_mi]) begin
                                r_mlock[r_mi] <= 1'b1;
                                r_mown[r_mi]  <= c;
                            end else begin
                                // append caller to the mutex wait list
                                r_wlink[c] <= NIL;
                                if (r_wt[r_mi] != NIL)
                                    r_wlink[r_wt[r_mi][SLOT_W-1:0]] <= PTR_W'(c);
                                else
                                    r_wh[r_mi] <= PTR_W'(c);
                                r_wt[r_mi] <= PTR_W'(c);
                                r_lvl[c]   <= c_credit;
                                r_state[c] <= TS_BLOCKED;
                                r_status   <= RS_WAITING;
                            end
                        end
                        ACT_UNLOCK: begin
                            if (!mi_ok) begin
                                r_status <= RS_IGNORED;
                            end else if (mw != NIL) begin
                                // direct handoff to the first waiter
                                r_wh[r_mi] <= r_wlink[uw];
                                if (r_wlink[uw] == NIL) r_wt[r_mi] <= NIL;
                                r_wlink[uw]  <= NIL;
                                r_mown[r_mi] <= uw;
                                if (r_state[uw] == TS_BLOCKED && r_lvl[uw] < r_lvl[c])
                                    r_resched <= 1'b1;
                            end else begin
                                r_mlock[r_mi] <= 1'b0;
                                r_mown[r_mi]  <= '0;
                            end
                        end
                        default: r_status <= RS_IGNORED;
                    endcase
                end
                OP_DDEQ: begin
                    if (best_ok) begin
                        r_qh[best_p] <= r_link[nx];
                        if (r_link[nx] == NIL) r_qt[best_p] <= NIL;
                        r_link[nx] <= NIL;
                    end
                    r_resched  <= 1'b0;
                    r_state[nx] <= TS_RUNNING;
                    r_slice[nx] <= slice_for(r_bq, r_lvl[nx]);
                    r_cur      <= nx;
                end
                OP_TINC: begin
                    r_tick <= r_tick + TICK_W'(1);
                    r_i    <= '0;
                end
                OP_WAKE: begin
                    // promotion scan starts at slot 1
                    r_i <= (r_i == SLOT_W'(THREADS - 1)) ? SLOT_W'(1) : r_i + SLOT_W'(1);
                end
                OP_PCHK: begin
                    if (promo_hit) begin
                        r_it    <= r_qh[r_lvl[r_i]];
                        r_prev  <= NIL;
                        r_steps <= '0;
                    end else begin
                        r_i <= r_i + SLOT_W'(1);
                    end
                end
                OP_WALK: begin
                    if (walk_go) begin
                        r_prev  <= r_it;
                        r_it    <= r_link[r_it[SLOT_W-1:0]];
                        r_steps <= r_steps + PTR_W'(1);
                    end
                end
                OP_UNLK: begin
                    if (r_it == PTR_W'(r_i)) begin
                        if (r_prev != NIL) r_link[r_prev[SLOT_W-1:0]] <= r_link[r_i];
                        else r_qh[r_lvl[r_i]] <= r_link[r_i];
                        if (r_qt[r_lvl[r_i]] == PTR_W'(r_i)) r_qt[r_lvl[r_i]] <= r_prev;
                        r_link[r_i] <= NIL;
                    end
                end
                OP_PENQ: begin
                    r_lvl[r_i] <= r_lvl[r_i] - LVL_W'(1);
                    r_resched  <= 1'b1;
                    r_i        <= r_i + SLOT_W'(1);
                end
                OP_SLICE: begin
                    if (c != '0) begin
                        r_slice[c] <= s_dec;
                        if (s_dec == '0) begin
                            if (int'(r_lvl[c]) + 1 < LEVELS) r_lvl[c] <= r_lvl[c] + LVL_W'(1);
                            r_resched <= 1'b1;
                        end
                    end
                end
                OP_BEST: begin
                    if (best_ok && (c == '0 || best_p < r_lvl[c])) r_resched <= 1'b1;
                    if (o_stat.boost_due) begin
                        // park the old queues, rebuild them from empty
                        r_lboost  <= r_tick;
                        r_resched <= 1'b1;
                        for (int p = 0; p < LEVELS; p++) begin
                            r_oh[p] <= r_qh[p];
                            r_qh[p] <= NIL;
                            r_qt[p] <= NIL;
                        end
                        r_bl <= '0;
                        r_it <= r_qh[0];
                    end
                end
                OP_BOOST: begin
                    if (r_it != NIL) begin
                        r_it <= r_link[r_it[SLOT_W-1:0]];
                        r_lvl[r_it[SLOT_W-1:0]] <= r_base[r_it[SLOT_W-1:0]];
                    end else if (r_bl != LVL_W'(LEVELS - 1)) begin
                        r_bl <= r_bl + LVL_W'(1);
                        r_it <= r_oh[r_bl + LVL_W'(1)];
                    end
                end
                OP_BFIX: begin
                    for (int t = 0; t < THREADS; t++) begin
                        if (r_state[t] == TS_SLEEPING || r_state[t] == TS_BLOCKED)
                            r_lvl[t] <= r_base[t];
                    end
                end
                default: ;
            endcase
            if (enq_en) begin
                r_state[enq_t] <= TS_READY;
                r_link[enq_t]  <= NIL;
                r_age[enq_t]   <= r_tick;
                if (r_qt[enq_p] != NIL) r_link[r_qt[enq_p][SLOT_W-1:0]] <= PTR_W'(enq_t);
                else r_qh[enq_p] <= PTR_W'(enq_t);
                r_qt[enq_p] <= PTR_W'(enq_t);
            end
        end
    end

    assign o_running_slot    = r_cur;
    assign o_switched        = (r_cur != r_before);
    assign o_resched_pending = r_resched;
    assign o_new_slot        = r_created;
    assign o_status          = r_status;

endmodule

// ===== rtl/mfts_ctrl.sv =====
// scheduler sequencer: steps the datapath through each command
module mfts_ctrl import mfts_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op,
    output logic     o_busy,
    output logic     o_done
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_EXEC  = 12'b0000_0000_0010,
        S_DENQ  = 12'b0000_0000_0100,
        S_DDEQ  = 12'b0000_0000_1000,
        S_WAKE  = 12'b0000_0001_0000,
        S_PCHK  = 12'b0000_0010_0000,
        S_WALK  = 12'b0000_0100_0000,
        S_PENQ  = 12'b0000_1000_0000,
        S_SLICE = 12'b0001_0000_0000,
        S_BEST  = 12'b0010_0000_0000,
        S_BOOST = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op    = OP_LATCH;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_tick) begin
                    o_op    = OP_TINC;
                    n_state = S_WAKE;
                end else begin
                    o_op    = OP_EXEC;
                    n_state = i_stat.disp ? S_DENQ : S_DONE;
                end
            end
            S_DENQ: begin
                o_op    = OP_DENQ;
                n_state = S_DDEQ;
            end
            S_DDEQ: begin
                o_op    = OP_DDEQ;
                n_state = S_DONE;
            end
            S_WAKE: begin
                o_op = OP_WAKE;
                if (i_stat.i_last) n_state = S_PCHK;
            end
            S_PCHK: begin
                o_op = OP_PCHK;
                if (i_stat.promo) n_state = S_WALK;
                else if (i_stat.i_last) n_state = S_SLICE;
            end
            S_WALK: begin
                // find the predecessor, then unlink in the same step
                if (i_stat.walk_done) begin
                    o_op    = OP_UNLK;
                    n_state = S_PENQ;
                end else begin
                    o_op = OP_WALK;
                end
            end
            S_PENQ: begin
                o_op    = OP_PENQ;
                n_state = i_stat.i_last ? S_SLICE : S_PCHK;
            end
            S_SLICE: begin
                o_op    = OP_SLICE;
                n_state = S_BEST;
            end
            S_BEST: begin
                o_op    = OP_BEST;
                n_state = i_stat.boost_due ? S_BOOST : S_DONE;
            end
            S_BOOST: begin
                if (i_stat.boost_end) begin
                    o_op    = OP_BFIX;
                    n_state = S_DONE;
                end else begin
                    o_op = OP_BOOST;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

// ===== rtl/multilevel_feedback_thread_scheduler_top.sv =====
// a command steps IDLE (latch), EXEC and DONE; one that dispatches also passes DENQ and DDEQ
// tick: TINC, a WAKE slot scan, a PCHK scan with WALK and PENQ per promoted thread, SLICE, BEST,
//   plus BOOST over the queued threads and levels when the boost runs; one shared queue port serializes this
// one command at a time; the next is taken the cycle after o_done
// sync active-low reset: slot 0 running, queues empty, config at defaults
module multilevel_feedback_thread_scheduler_top import mfts_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [ACT_W-1:0]    i_action,
    input  logic [SLOT_W-1:0]   i_thread_slot,
    input  logic [PRIO_W-1:0]   i_priority_req,
    input  logic [TICK_W-1:0]   i_sleep_ticks,
    input  logic [MI_W-1:0]     i_mutex_index,
    output logic                o_done,
    output logic [SLOT_W-1:0]   o_running_slot,
    output logic                o_switched,
    output logic                o_resched_pending,
    output logic [SLOT_W-1:0]   o_new_slot,
    output logic [STAT_W-1:0]   o_status,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CDAT_W-1:0]   i_cfg_data
);

    t_dp_op   dp_op;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    mfts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_op    (dp_op),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    mfts_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (dp_op),
        .o_stat            (dp_stat),
        .i_action          (i_action),
        .i_thread_slot     (i_thread_slot),
        .i_priority_req    (i_priority_req),
        .i_sleep_ticks     (i_sleep_ticks),
        .i_mutex_index     (i_mutex_index),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_running_slot    (o_running_slot),
        .o_switched        (o_switched),
        .o_resched_pending (o_resched_pending),
        .o_new_slot        (o_new_slot),
        .o_status          (o_status)
    );

endmodule

// ===== rtl/mfts_chk.sv =====
// port-level checks on the thread scheduler, bound to the top level
`include "multilevel_feedback_thread_scheduler_top_defines.svh"

module mfts_chk import mfts_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input logic [SLOT_W-1:0] o_running_slot,
    input logic              o_switched,
    input logic              o_resched_pending,
    input logic [SLOT_W-1:0] o_new_slot,
    input logic [STAT_W-1:0] o_status
);

    // an accepted word makes the block busy
    `MFTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // a result word ends the command
    `MFTS_ASSERT_NEXT(a_done_idle, o_done, !busy)
    // a switch comes only from a dispatch, which clears the request
    `MFTS_ASSERT_NOW(a_switch_clears, o_done && o_switched, !o_resched_pending)
    // a failed create hands out no slot
    `MFTS_ASSERT_NOW(a_noslot_zero, o_done && o_status == RS_NOSLOT, o_new_slot == '0)
    // nothing moves the running slot while idle
    `MFTS_ASSERT_NEXT(a_idle_stable, !busy && !start, $stable(o_running_slot))

endmodule

bind multilevel_feedback_thread_scheduler_top mfts_chk u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_running_slot    (o_running_slot),
    .o_switched        (o_switched),
    .o_resched_pending (o_resched_pending),
    .o_new_slot        (o_new_slot),
    .o_status          (o_status)
);

// ===== tb/tb_top.sv =====
// self-checking testbench for the multilevel feedback thread scheduler
`timescale 1ns / 100ps

module tb_top;
    import mfts_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 8;

    typedef enum logic [1:0] {K_CMD, K_CFG, K_DRAIN} t_kind;

    typedef struct {
        t_kind              kind;
        logic [ACT_W-1:0]   action;
        logic [SLOT_W-1:0]  slot;
        logic [PRIO_W-1:0]  prio;
        logic [TICK_W-1:0]  ticks;
        logic [MI_W-1:0]    mi;
        logic [CIDX_W-1:0]  cidx;
        logic [CDAT_W-1:0]  cdata;
    } t_word;

    typedef struct {
        logic [SLOT_W-1:0]  running;
        logic               switched;
        logic               resched;
        logic [SLOT_W-1:0]  new_slot;
        logic [STAT_W-1:0]  status;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [ACT_W-1:0]  i_action = '0;
    logic [SLOT_W-1:0] i_thread_slot = '0;
    logic [PRIO_W-1:0] i_priority_req = '0;
    logic [TICK_W-1:0] i_sleep_ticks = '0;
    logic [MI_W-1:0]   i_mutex_index = '0;
    logic o_done;
    logic [SLOT_W-1:0] o_running_slot;
    logic o_switched;
    logic o_resched_pending;
    logic [SLOT_W-1:0] o_new_slot;
    logic [STAT_W-1:0] o_status;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [CDAT_W-1:0] i_cfg_data = '0;

    t_word    cmd_queue[$];
    t_outcome expected_results[$];
    int       errors = 0;

    multilevel_feedback_thread_scheduler_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_thread_slot(i_thread_slot),
        .i_priority_req(i_priority_req), .i_sleep_ticks(i_sleep_ticks),
        .i_mutex_index(i_mutex_index), .o_done(o_done),
        .o_running_slot(o_running_slot), .o_switched(o_switched),
        .o_resched_pending(o_resched_pending), .o_new_slot(o_new_slot),
        .o_status(o_status), .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // scheduler shadow state
    logic [7:0]        quantum = 8'd4;
    logic [LIM_W-1:0]  starve = 16'd100;
    logic [LIM_W-1:0]  boost = 16'd1000;
    logic [2:0]        tstate [THREADS];
    logic [LVL_W-1:0]  lvl [THREADS];
    logic [LVL_W-1:0]  base_lvl [THREADS];
    logic [31:0]       slice [THREADS];
    logic [TICK_W-1:0] wake_at [THREADS];
    logic [TICK_W-1:0] aged_at [THREADS];
    logic [PTR_W-1:0]  qlink [THREADS];
    logic [PTR_W-1:0]  qhead [LEVELS];
    logic [PTR_W-1:0]  qtail [LEVELS];
    logic [PTR_W-1:0]  wlink [THREADS];
    logic              mlocked [MUTEXES];
    logic [SLOT_W-1:0] mowner [MUTEXES];
    logic [PTR_W-1:0]  whead [MUTEXES];
    logic [PTR_W-1:0]  wtail [MUTEXES];
    logic [SLOT_W-1:0] cur;
    logic [TICK_W-1:0] now_tick;
    logic [TICK_W-1:0] boost_at;
    logic              resched;

    initial begin
        for (int i = 0; i < THREADS; i++) begin
            tstate[i] = TS_UNUSED; lvl[i] = '0; base_lvl[i] = '0; slice[i] = 0;
            wake_at[i] = '0; aged_at[i] = '0; qlink[i] = NIL; wlink[i] = NIL;
        end
        tstate[0] = TS_RUNNING;
        lvl[0] = LVL_W'(LEVELS - 1);
        base_lvl[0] = LVL_W'(LEVELS - 1);
        for (int p = 0; p < LEVELS; p++) begin
            qhead[p] = NIL; qtail[p] = NIL;
        end
        for (int m = 0; m < MUTEXES; m++) begin
            mlocked[m] = 1'b0; mowner[m] = '0; whead[m] = NIL; wtail[m] = NIL;
        end
        cur = '0; now_tick = '0; boost_at = '0; resched = 1'b0;
    end

    function automatic logic [31:0] slice_len(logic [LVL_W-1:0] lv);
        return 32'(quantum) << lv;
    endfunction

    function automatic void run_enqueue(logic [SLOT_W-1:0] t);
        logic [LVL_W-1:0] p;
        p = lvl[t];
        tstate[t] = TS_READY;
        qlink[t] = NIL;
        aged_at[t] = now_tick;
        if (qtail[p] < THREADS) qlink[qtail[p][SLOT_W-1:0]] = {1'b0, t};
        else qhead[p] = {1'b0, t};
        qtail[p] = {1'b0, t};
    endfunction

    function automatic void run_unlink(logic [SLOT_W-1:0] t);
        logic [LVL_W-1:0] p;
        logic [PTR_W-1:0] prv;
        logic [PTR_W-1:0] it;
        int steps;
        p = lvl[t];
        prv = NIL;
        it = qhead[p];
        steps = 0;
        while (it < THREADS && it != {1'b0, t} && steps < THREADS) begin
            prv = it;
            it = qlink[it[SLOT_W-1:0]];
            steps++;
        end
        if (it != {1'b0, t}) return;
        if (prv < THREADS) qlink[prv[SLOT_W-1:0]] = qlink[t];
        else qhead[p] = qlink[t];
        if (qtail[p] == {1'b0, t}) qtail[p] = prv;
        qlink[t] = NIL;
    endfunction

    function automatic logic [PTR_W-1:0] run_dequeue();
        logic [PTR_W-1:0] h;
        for (int p = 0; p < LEVELS; p++) begin
            h = qhead[p];
            if (h < THREADS) begin
                qhead[p] = qlink[h[SLOT_W-1:0]];
                if (qhead[p] >= THREADS) qtail[p] = NIL;
                qlink[h[SLOT_W-1:0]] = NIL;
                return h;
            end
        end
        return NIL;
    endfunction

    function automatic int top_ready_level();
        for (int p = 0; p < LEVELS; p++)
            if (qhead[p] < THREADS) return p;
        return LEVELS;
    endfunction

    function automatic void switch_thread();
        logic [PTR_W-1:0] nx;
        if (tstate[cur] == TS_READY && cur != 0) run_enqueue(cur);
        nx = run_dequeue();
        if (nx >= THREADS) nx = '0;
        resched = 1'b0;
        tstate[nx[SLOT_W-1:0]] = TS_RUNNING;
        slice[nx[SLOT_W-1:0]] = slice_len(lvl[nx[SLOT_W-1:0]]);
        cur = nx[SLOT_W-1:0];
    endfunction

    function automatic void reward(logic [SLOT_W-1:0] t);
        if (lvl[t] > base_lvl[t]) lvl[t]--;
    endfunction

    function automatic void boost_levels();
        logic [SLOT_W-1:0] order [THREADS];
        logic [PTR_W-1:0]  it;
        int cnt;
        cnt = 0;
        for (int p = 0; p < LEVELS; p++) begin
            it = qhead[p];
            while (it < THREADS && cnt < THREADS) begin
                order[cnt++] = it[SLOT_W-1:0];
                it = qlink[it[SLOT_W-1:0]];
            end
            qhead[p] = NIL;
            qtail[p] = NIL;
        end
        for (int k = 0; k < cnt; k++) begin
            lvl[order[k]] = base_lvl[order[k]];
            run_enqueue(order[k]);
        end
        for (int i = 0; i < THREADS; i++)
            if (tstate[i] == TS_SLEEPING || tstate[i] == TS_BLOCKED) lvl[i] = base_lvl[i];
    endfunction

    function automatic void tick_advance();
        logic [SLOT_W-1:0] c;
        logic [TICK_W-1:0] waited;
        int best;
        now_tick = now_tick + 1'b1;
        for (int i = 0; i < THREADS; i++)
            if (tstate[i] == TS_SLEEPING && wake_at[i] <= now_tick) run_enqueue(SLOT_W'(i));
        for (int i = 1; i < THREADS; i++) begin
            waited = now_tick - aged_at[i];
            if (tstate[i] == TS_READY && lvl[i] > 0 && waited >= TICK_W'(starve)) begin
                run_unlink(SLOT_W'(i));
                lvl[i]--;
                run_enqueue(SLOT_W'(i));
                resched = 1'b1;
            end
        end
        c = cur;
        if (c != 0) begin
            if (slice[c] > 0) slice[c]--;
            if (slice[c] == 0) begin
                if (int'(lvl[c]) + 1 < LEVELS) lvl[c]++;
                resched = 1'b1;
            end
        end
        best = top_ready_level();
        if (best < LEVELS && (c == 0 || best < int'(lvl[c]))) resched = 1'b1;
        waited = now_tick - boost_at;
        if (waited >= TICK_W'(boost)) begin
            boost_at = now_tick;
            boost_levels();
            resched = 1'b1;
        end
    endfunction

    function automatic t_outcome sched_step(t_word w);
        t_outcome r;
        logic [SLOT_W-1:0] was;
        logic [SLOT_W-1:0] c;
        logic [PRIO_W-1:0] pr;
        logic [PTR_W-1:0]  wt;
        int t;
        was = cur;
        c = cur;
        r.status = RS_DONE;
        r.new_slot = '0;
        case (w.action)
            ACT_TICK: tick_advance();
            ACT_CREATE: begin
                t = -1;
                for (int i = 0; i < THREADS; i++)
                    if (t < 0 && tstate[i] == TS_UNUSED) t = i;
                if (t < 0) begin
                    r.status = RS_NOSLOT;
                end else begin
                    pr = (w.prio >= LEVELS) ? PRIO_W'(LEVELS - 1) : w.prio;
                    base_lvl[t] = pr[LVL_W-1:0];
                    lvl[t] = pr[LVL_W-1:0];
                    slice[t] = slice_len(pr[LVL_W-1:0]);
                    wake_at[t] = '0;
                    wlink[t] = NIL;
                    run_enqueue(SLOT_W'(t));
                    if (lvl[t] < lvl[c]) resched = 1'b1;
                    r.new_slot = SLOT_W'(t);
                end
            end
            ACT_YIELD: begin
                reward(c); tstate[c] = TS_READY; switch_thread();
            end
            ACT_SLEEP: begin
                reward(c);
                if (w.ticks == 0) tstate[c] = TS_READY;
                else begin
                    wake_at[c] = now_tick + w.ticks;
                    tstate[c] = TS_SLEEPING;
                end
                switch_thread();
            end
            ACT_BLOCK: begin
                reward(c); tstate[c] = TS_BLOCKED; switch_thread();
            end
            ACT_WAKE: begin
                if (tstate[w.slot] == TS_BLOCKED || tstate[w.slot] == TS_SLEEPING) begin
                    run_enqueue(w.slot);
                    if (lvl[w.slot] < lvl[c]) resched = 1'b1;
                end else r.status = RS_IGNORED;
            end
            ACT_EXIT: begin
                tstate[c] = TS_ZOMBIE; switch_thread();
            end
            ACT_PREEMPT: begin
                if (!resched) r.status = RS_IGNORED;
                else begin
                    if (tstate[c] == TS_RUNNING) tstate[c] = TS_READY;
                    switch_thread();
                end
            end
            ACT_IDLE: begin
                if (c != 0 || top_ready_level() >= LEVELS) r.status = RS_IGNORED;
                else begin
                    tstate[0] = TS_READY; switch_thread();
                end
            end
            ACT_LOCK: begin
                if (!mlocked[w.mi]) begin
                    mlocked[w.mi] = 1'b1;
                    mowner[w.mi] = c;
                end else begin
                    wlink[c] = NIL;
                    if (wtail[w.mi] < THREADS) wlink[wtail[w.mi][SLOT_W-1:0]] = {1'b0, c};
                    else whead[w.mi] = {1'b0, c};
                    wtail[w.mi] = {1'b0, c};
                    reward(c);
                    tstate[c] = TS_BLOCKED;
                    switch_thread();
                    r.status = RS_WAITING;
                end
            end
            ACT_UNLOCK: begin
                wt = whead[w.mi];
                if (wt < THREADS) begin
                    whead[w.mi] = wlink[wt[SLOT_W-1:0]];
                    if (whead[w.mi] >= THREADS) wtail[w.mi] = NIL;
                    wlink[wt[SLOT_W-1:0]] = NIL;
                    mowner[w.mi] = wt[SLOT_W-1:0];
                    if (tstate[wt[SLOT_W-1:0]] == TS_BLOCKED) begin
                        run_enqueue(wt[SLOT_W-1:0]);
                        if (lvl[wt[SLOT_W-1:0]] < lvl[c]) resched = 1'b1;
                    end
                end else begin
                    mlocked[w.mi] = 1'b0;
                    mowner[w.mi] = '0;
                end
            end
            default: r.status = RS_IGNORED;
        endcase
        r.running = cur;
        r.switched = (cur != was);
        r.resched = resched;
        return r;
    endfunction

    function automatic void write_register(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] d);
        case (idx)
            CFG_QUANTUM: quantum = d[7:0];
            CFG_STARVE:  starve = d;
            CFG_BOOST:   boost = d;
            default: ;
        endcase
    endfunction

    // stimulus building
    function automatic void add_cmd(logic [ACT_W-1:0] a, logic [SLOT_W-1:0] s,
                                    logic [PRIO_W-1:0] p, logic [TICK_W-1:0] tk,
                                    logic [MI_W-1:0] m);
        t_word w;
        w.kind = K_CMD; w.action = a; w.slot = s; w.prio = p; w.ticks = tk; w.mi = m;
        w.cidx = '0; w.cdata = '0;
        cmd_queue.push_back(w);
    endfunction

    function automatic void add_settings(logic [CDAT_W-1:0] q, logic [CDAT_W-1:0] sl,
                                         logic [CDAT_W-1:0] bp);
        t_word w;
        w.kind = K_DRAIN; w.action = '0; w.slot = '0; w.prio = '0; w.ticks = '0; w.mi = '0;
        w.cidx = '0; w.cdata = '0;
        cmd_queue.push_back(w);
        w.kind = K_CFG;
        w.cidx = CFG_QUANTUM; w.cdata = q;  cmd_queue.push_back(w);
        w.cidx = CFG_STARVE;  w.cdata = sl; cmd_queue.push_back(w);
        w.cidx = CFG_BOOST;   w.cdata = bp; cmd_queue.push_back(w);
    endfunction

    function automatic void add_random_cmd();
        int r;
        logic [TICK_W-1:0] tk;
        logic [ACT_W-1:0] a;
        r = $urandom_range(0, 99);
        tk = $urandom_range(0, 99) < 75 ? TICK_W'($urandom_range(0, 12)) : $urandom;
        if (r < 30)      a = ACT_TICK;
        else if (r < 40) a = ACT_CREATE;
        else if (r < 48) a = ACT_YIELD;
        else if (r < 56) a = ACT_SLEEP;
        else if (r < 62) a = ACT_BLOCK;
        else if (r < 74) a = ACT_WAKE;
        else if (r < 76) a = ACT_EXIT;
        else if (r < 82) a = ACT_PREEMPT;
        else if (r < 86) a = ACT_IDLE;
        else if (r < 93) a = ACT_LOCK;
        else if (r < 99) a = ACT_UNLOCK;
        else             a = ACT_W'($urandom_range(11, 15));
        add_cmd(a, SLOT_W'($urandom), PRIO_W'($urandom), tk, MI_W'($urandom));
    endfunction

    initial begin
        // directed opening
        add_cmd(ACT_PREEMPT, 0, 0, 0, 0);
        add_cmd(ACT_IDLE, 0, 0, 0, 0);
        add_cmd(ACT_CREATE, 0, 0, 0, 0);
        add_cmd(ACT_CREATE, 0, 3, 0, 0);
        add_cmd(ACT_CREATE, 0, 7, 0, 0);
        add_cmd(ACT_TICK, 0, 0, 0, 0);
        add_cmd(ACT_PREEMPT, 0, 0, 0, 0);
        add_cmd(ACT_YIELD, 0, 0, 0, 0);
        add_cmd(ACT_SLEEP, 0, 0, 0, 0);
        add_cmd(ACT_SLEEP, 0, 0, 5, 0);
        add_cmd(ACT_SLEEP, 0, 0, 32'hFFFF_FFFF, 0);
        add_cmd(ACT_TICK, 0, 0, 0, 0);
        add_cmd(ACT_LOCK, 0, 0, 0, 0);
        add_cmd(ACT_LOCK, 0, 0, 0, 0);
        add_cmd(ACT_UNLOCK, 0, 0, 0, 0);
        add_cmd(ACT_UNLOCK, 0, 0, 0, 3);
        add_cmd(ACT_BLOCK, 0, 0, 0, 0);
        add_cmd(ACT_WAKE, 1, 0, 0, 0);
        add_cmd(ACT_WAKE, 15, 0, 0, 0);
        add_cmd(ACT_WAKE, 0, 0, 0, 0);
        add_cmd(4'd11, 0, 0, 0, 0);
        add_cmd(4'd15, 15, 7, 0, 3);
        add_cmd(ACT_EXIT, 0, 0, 0, 0);
        add_cmd(ACT_IDLE, 0, 0, 0, 0);
        add_cmd(ACT_TICK, 0, 0, 0, 0);
        for (int k = 0; k < 120; k++) add_random_cmd();
        add_settings(16'd1, 16'd3, 16'd20);
        for (int k = 0; k < 150; k++) add_random_cmd();
        add_settings(16'd255, 16'd65535, 16'd65535);
        for (int k = 0; k < 110; k++) add_random_cmd();
        add_settings(16'd0, 16'd0, 16'd0);
        for (int k = 0; k < 110; k++) add_random_cmd();
        add_settings(16'd2, 16'd1, 16'd1);
        for (int k = 0; k < 110; k++) add_random_cmd();
        add_settings(16'($urandom_range(1, 8)), 16'($urandom_range(2, 12)),
                     16'($urandom_range(10, 60)));
        for (int k = 0; k < 200; k++) add_random_cmd();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (cmd_queue.size() != 0 || expected_results.size() != 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("tb_top OK");
        else $display("tb_top NOT OK");
        $finish;
    end

    // driver
    int burst_left = 1;
    int gap_left = 0;
    int settle = 0;

    always @(posedge i_clk) begin : driver
        logic next_start;
        logic cfg_open;
        t_word w;
        next_start = start;
        cfg_open = i_cfg_valid;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_results.push_back(sched_step(cmd_queue[0]));
                cmd_queue.pop_front();
                next_start = 1'b0;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                write_register(cmd_queue[0].cidx, cmd_queue[0].cdata);
                cmd_queue.pop_front();
                cfg_open = 1'b0;
            end
            if (!next_start && !cfg_open && cmd_queue.size() != 0) begin
                w = cmd_queue[0];
                case (w.kind)
                    K_CMD: begin
                        if (gap_left > 0) gap_left--;
                        else begin
                            i_action <= w.action;
                            i_thread_slot <= w.slot;
                            i_priority_req <= w.prio;
                            i_sleep_ticks <= w.ticks;
                            i_mutex_index <= w.mi;
                            next_start = 1'b1;
                        end
                    end
                    K_CFG: begin
                        i_cfg_index <= w.cidx;
                        i_cfg_data <= w.cdata;
                        cfg_open = 1'b1;
                    end
                    default: begin
                        // hold off until the block has gone quiet
                        if (expected_results.size() == 0) begin
                            if (settle < SETTLE_CYCLES) settle++;
                            else begin
                                settle = 0;
                                cmd_queue.pop_front();
                            end
                        end
                    end
                endcase
            end
        end
        start <= next_start;
        i_cfg_valid <= cfg_open;
    end

    // monitor
    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_outcome e;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected word expected none actual slot %0d", $time,
                         o_running_slot);
            end else begin
                e = expected_results.pop_front();
                check_field("running_slot", e.running, o_running_slot);
                check_field("switched", e.switched, o_switched);
                check_field("resched_pending", e.resched, o_resched_pending);
                check_field("new_slot", e.new_slot, o_new_slot);
                check_field("status", e.status, o_status);
            end
        end
    end

    // watchdog
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
